>>> design/sfla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types and constants for the segregated free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int NUM_FLOORS = 8;
    localparam int SIZE_W     = 17;
    localparam int PTR_W      = 17;   // valid, region[1:0], word offset[13:0]
    localparam int HIDX_W     = 16;
    localparam int HDR_DEPTH  = 65536;
    localparam int CLS_W      = 3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BAD     = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [SIZE_W-1:0] t_size;
    typedef logic [PTR_W-1:0]  t_ptr;

    localparam t_size RESET_FLOORS [NUM_FLOORS] = '{
        17'd16, 17'd32, 17'd64, 17'd128, 17'd256, 17'd512, 17'd1024, 17'd4096
    };

    typedef struct packed {
        logic        opcode;
        logic [15:0] req_bytes;
        logic [1:0]  free_region;
        logic [15:0] free_offset;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  got_region;
        logic [15:0] got_offset;
    } t_out_item;

    typedef struct packed {
        logic             put_ok;
        logic [CLS_W-1:0] put_idx;
        logic [CLS_W-1:0] get_idx;
    } t_cls;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_OPEN, S_LAST, S_POP, S_SPLIT, S_FREE, S_RESP
    } t_state;

    // class a block of this size lands in under the reset floors; bit 3 = kept
    function automatic logic [3:0] f_reset_class(input t_size size, input int nb);
        logic [3:0] r;
        logic       hit;
        r   = {1'b1, CLS_W'(nb - 1)};
        hit = 1'b0;
        for (int i = 0; i < NUM_FLOORS; i++) begin
            if (i < nb && !hit && RESET_FLOORS[i] > size) begin
                hit = 1'b1;
                if (i == 0) r = 4'd0;
                else        r = {1'b1, CLS_W'(i - 1)};
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

>>> design/sfla_class.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sfla_class
// Size class lookup: class for pushing a block, first class for a request.
// ----------------------------------------------------------------------------
module sfla_class
    import sfla_pkg::*;
#(
    parameter int NUM_BUCKETS = 8
) (
    input  wire t_size i_floors [NUM_FLOORS],
    input  wire t_size i_put_size,
    input  wire t_size i_get_size,
    output t_cls       o_cls
);

    always_comb begin
        logic ph, gh;
        o_cls.put_ok  = 1'b1;
        o_cls.put_idx = CLS_W'(NUM_BUCKETS - 1);
        o_cls.get_idx = CLS_W'(NUM_BUCKETS - 1);
        ph = 1'b0;
        gh = 1'b0;
        for (int i = 0; i < NUM_FLOORS; i++) begin
            if (i < NUM_BUCKETS) begin
                if (!ph && i_floors[i] > i_put_size) begin
                    ph = 1'b1;
                    if (i == 0) begin
                        o_cls.put_ok  = 1'b0;
                        o_cls.put_idx = '0;
                    end else begin
                        o_cls.put_idx = CLS_W'(i - 1);
                    end
                end
                if (!gh && i_floors[i] >= i_get_size) begin
                    gh = 1'b1;
                    o_cls.get_idx = CLS_W'(i);
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> design/segregated_free_list_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_top
// Alloc/free over per-class free lists threaded through a header memory.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid/o_in_stall  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/i_out_stall| o_out_data (t_out_item)
//  cfg     | input     | i_cfg_we               | i_cfg_index, i_cfg_data
//
//  One request at a time, from the accepting edge back to idle: a free goes
//  through S_FREE and S_RESP, a rejected request straight to S_RESP, and an
//  alloc through scan, optional region open and last-class check, header pop,
//  optional split push and result load. Header memory reads are registered.
//  After reset S_INIT writes the first region's header before any input.
//  A result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_top
    import sfla_pkg::*;
#(
    parameter int NUM_BUCKETS  = 8,
    parameter int REGION_BYTES = 65536,
    parameter int MAX_REGIONS  = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output t_out_item        o_out_data,
    input  wire              i_cfg_we,
    input  wire [2:0]        i_cfg_index,
    input  wire [SIZE_W-1:0] i_cfg_data
);

    localparam t_size      REG_SIZE   = SIZE_W'(REGION_BYTES - 4);
    localparam logic [3:0] INIT_CLS   = f_reset_class(REG_SIZE, NUM_BUCKETS);
    localparam logic [2:0] MAX_REG    = 3'(MAX_REGIONS);
    localparam logic [CLS_W-1:0] LAST = CLS_W'(NUM_BUCKETS - 1);

    t_state          r_state, n_state;
    t_size           r_floors [NUM_FLOORS];
    t_ptr            r_heads [NUM_FLOORS], n_heads [NUM_FLOORS];
    logic [2:0]      r_regions_used, n_regions_used;
    t_size           r_size, n_size;
    logic [CLS_W-1:0] r_bkt, n_bkt;
    t_ptr            r_ptr, n_ptr;
    t_ptr            r_rem_ptr, n_rem_ptr;
    t_size           r_rem_size, n_rem_size;
    t_out_item       r_res, n_res;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;

    logic [2*SIZE_W-1:0] r_hdr [HDR_DEPTH];
    logic [2*SIZE_W-1:0] r_rd_data;
    logic                mem_we;
    logic [HIDX_W-1:0]   mem_wa, mem_ra;
    logic [2*SIZE_W-1:0] mem_wd;

    t_size put_size, get_size;
    t_cls  cls;

    sfla_class #(.NUM_BUCKETS(NUM_BUCKETS)) u_class (
        .i_floors   (r_floors),
        .i_put_size (put_size),
        .i_get_size (get_size),
        .o_cls      (cls)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hdr[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_hdr[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_INIT;
            r_regions_used <= 3'd1;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < NUM_FLOORS; i++) begin
                r_floors[i] <= RESET_FLOORS[i];
                r_heads[i]  <= (INIT_CLS[3] && CLS_W'(i) == INIT_CLS[2:0]) ?
                               {1'b1, 16'd0} : 17'd0;
            end
        end else begin
            r_state        <= n_state;
            r_regions_used <= n_regions_used;
            r_out_valid    <= n_out_valid;
            r_heads        <= n_heads;
            if (i_cfg_we) begin
                r_floors[i_cfg_index] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_size     <= n_size;
        r_bkt      <= n_bkt;
        r_ptr      <= n_ptr;
        r_rem_ptr  <= n_rem_ptr;
        r_rem_size <= n_rem_size;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    always_comb begin
        logic             found;
        logic [CLS_W-1:0] fb;
        logic [16:0]      roff;
        t_size            bs;
        t_ptr             nxt;
        n_state        = r_state;
        n_heads        = r_heads;
        n_regions_used = r_regions_used;
        n_size         = r_size;
        n_bkt          = r_bkt;
        n_ptr          = r_ptr;
        n_rem_ptr      = r_rem_ptr;
        n_rem_size     = r_rem_size;
        n_res          = r_res;
        n_out          = r_out;
        n_out_valid    = r_out_valid && i_out_stall;
        mem_we         = 1'b0;
        mem_wa         = '0;
        mem_wd         = '0;
        mem_ra         = r_ptr[HIDX_W-1:0];
        o_in_stall     = (r_state != S_IDLE);
        put_size       = REG_SIZE;
        get_size       = r_size;
        found          = 1'b0;
        fb             = LAST;
        roff           = '0;
        bs             = r_rd_data[2*SIZE_W-1:SIZE_W];
        nxt            = r_rd_data[SIZE_W-1:0];

        case (r_state)
            S_INIT: begin
                mem_we  = 1'b1;
                mem_wa  = '0;
                mem_wd  = {REG_SIZE, 17'd0};
                n_state = S_IDLE;
            end
            S_IDLE: begin
                mem_ra = {i_in_data.free_region, i_in_data.free_offset[15:2]};
                if (i_in_valid) begin
                    n_res = '0;
                    n_ptr = {1'b1, i_in_data.free_region, i_in_data.free_offset[15:2]};
                    n_size = ({1'b0, i_in_data.req_bytes} + 17'd3) & 17'h1fffc;
                    if (i_in_data.opcode == OP_FREE) begin
                        if ({1'b0, i_in_data.free_region} >= r_regions_used
                                || i_in_data.free_offset[1:0] != 2'd0
                                || {1'b0, i_in_data.free_offset} > REG_SIZE) begin
                            n_res.status = ST_BAD;
                            n_state      = S_RESP;
                        end else begin
                            n_state = S_FREE;
                        end
                    end else if (i_in_data.req_bytes == 16'd0) begin
                        n_res.status = ST_BAD;
                        n_state      = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                for (int i = 0; i < NUM_FLOORS; i++) begin
                    if (i < NUM_BUCKETS && !found && CLS_W'(i) >= cls.get_idx
                            && r_heads[i][PTR_W-1]) begin
                        found = 1'b1;
                        fb    = CLS_W'(i);
                    end
                end
                if (found) begin
                    n_bkt   = fb;
                    n_ptr   = r_heads[fb];
                    mem_ra  = r_heads[fb][HIDX_W-1:0];
                    n_state = S_POP;
                end else if (r_regions_used >= MAX_REG) begin
                    n_res.status = ST_NOSPACE;
                    n_state      = S_RESP;
                end else begin
                    n_state = S_OPEN;
                end
            end
            S_OPEN: begin
                mem_we = 1'b1;
                mem_wa = {r_regions_used[1:0], 14'd0};
                mem_wd = {REG_SIZE, cls.put_ok ? r_heads[cls.put_idx] : 17'd0};
                if (cls.put_ok) begin
                    n_heads[cls.put_idx] = {1'b1, r_regions_used[1:0], 14'd0};
                end
                n_regions_used = r_regions_used + 3'd1;
                n_state        = S_LAST;
            end
            S_LAST: begin
                if (r_heads[LAST][PTR_W-1]) begin
                    n_bkt   = LAST;
                    n_ptr   = r_heads[LAST];
                    mem_ra  = r_heads[LAST][HIDX_W-1:0];
                    n_state = S_POP;
                end else begin
                    n_res.status = ST_NOSPACE;
                    n_state      = S_RESP;
                end
            end
            S_POP: begin
                if (bs < r_size) begin
                    n_res.status = ST_NOSPACE;
                    n_state      = S_RESP;
                end else begin
                    n_heads[r_bkt]   = nxt;
                    n_res.status     = ST_DONE;
                    n_res.got_region = r_ptr[15:14];
                    n_res.got_offset = {r_ptr[13:0], 2'b00};
                    roff = {1'b0, r_ptr[13:0], 2'b00} + 17'd4 + r_size;
                    n_rem_ptr  = {1'b1, r_ptr[15:14], roff[15:2]};
                    n_rem_size = bs - r_size - 17'd4;
                    if ({1'b0, bs - r_size} >= {1'b0, r_floors[0]} + 18'd4) begin
                        mem_we  = 1'b1;
                        mem_wa  = r_ptr[HIDX_W-1:0];
                        mem_wd  = {r_size, nxt};
                        n_state = S_SPLIT;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SPLIT: begin
                put_size = r_rem_size;
                mem_we   = 1'b1;
                mem_wa   = r_rem_ptr[HIDX_W-1:0];
                mem_wd   = {r_rem_size, cls.put_ok ? r_heads[cls.put_idx] : 17'd0};
                if (cls.put_ok) begin
                    n_heads[cls.put_idx] = r_rem_ptr;
                end
                n_state = S_RESP;
            end
            S_FREE: begin
                put_size = bs;
                if (cls.put_ok) begin
                    mem_we               = 1'b1;
                    mem_wa               = r_ptr[HIDX_W-1:0];
                    mem_wd               = {bs, r_heads[cls.put_idx]};
                    n_heads[cls.put_idx] = r_ptr;
                end
                n_res.status = ST_DONE;
                n_state      = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state != S_IDLE))
        else $error("accepted request did not start");
    a_regions_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_regions_used >= 3'd1 && r_regions_used <= MAX_REG))
        else $error("regions_used out of range");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status != ST_DONE) |->
        (o_out_data.got_region == 2'd0 && o_out_data.got_offset == 16'd0))
        else $error("failed result carries an address");
    a_open_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OPEN) |=> (r_regions_used == $past(r_regions_used) + 3'd1))
        else $error("region open not counted");
`endif

endmodule
`default_nettype wire
